[rtl/core/uniform_grid_particle_binning_defines.svh]
// Assertion macros shared by the checker of the particle binning block.
`ifndef UNIFORM_GRID_PARTICLE_BINNING_DEFINES_SVH
`define UNIFORM_GRID_PARTICLE_BINNING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UGPB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UGPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ugpb_pkg.sv]
// Package with types, constants and helpers of the particle binning block.
`timescale 1ns / 1ps
`default_nettype none
package ugpb_pkg;
  localparam int MAX_CELLS     = 1024;
  localparam int CELL_CAPACITY = 16;
  localparam int ID_BITS       = 16;

  localparam int IDX_W   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W   = $clog2(CELL_CAPACITY + 1);
  localparam int ENT_D   = MAX_CELLS * CELL_CAPACITY;
  localparam int ENT_AW  = (ENT_D > 1) ? $clog2(ENT_D) : 1;
  localparam int COORD_W = 24;
  localparam int SCALE_W = 24;
  localparam int DIM_W   = 11;
  localparam int QRY_W   = 10;
  localparam int IDXF_W  = 2 * DIM_W;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [ID_BITS-1:0] id;
    logic [IDX_W-1:0]   idx;
    logic               ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [4:0]       count;
    logic [15:0]      id;
    logic             last;
  } res_t;

  function automatic logic [ENT_AW-1:0] ent_addr(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] slot);
    logic [ENT_AW+IDX_W-1:0] prod;
    prod = (ENT_AW+IDX_W)'(idx) * (ENT_AW+IDX_W)'(CELL_CAPACITY)
           + (ENT_AW+IDX_W)'(slot);
    return prod[ENT_AW-1:0];
  endfunction
endpackage
`default_nettype wire

[rtl/core/ugpb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ugpb_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/core/ugpb_front.sv]
// Front end: accepts items, scales coordinates and resolves the cell index.
`timescale 1ns / 1ps
`default_nettype none
module ugpb_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ugpb_pkg::cfg_t               cfg,
  input  wire logic                         hold,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [1:0]                   in_operation,
  input  wire logic [15:0]                  in_particle_id,
  input  wire logic [23:0]                  in_x_coord,
  input  wire logic [23:0]                  in_y_coord,
  input  wire logic [9:0]                   in_query_row,
  input  wire logic [9:0]                   in_query_col,
  output logic                              cmd_push,
  output ugpb_pkg::cmd_t                    cmd,
  input  wire logic                         cmd_full
);
  import ugpb_pkg::*;

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_MUL  = 2'd1;
  localparam logic [1:0] FS_IDX  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         op_r;
  logic [ID_BITS-1:0] id_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [QRY_W-1:0]   qr_r, qc_r;
  logic [COORD_W-1:0] pcol_r, prow_r;
  logic [2*COORD_W-1:0] mx, my;
  logic [COORD_W-1:0] row, col;
  logic               inb;
  logic [IDXF_W-1:0]  idxf;
  logic               accept;

  assign in_full = (state_r != FS_IDLE) || hold;
  assign accept  = in_push && !in_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: if (accept && in_operation != OP_NONE) state_nxt = FS_MUL;
      FS_MUL:  state_nxt = FS_IDX;
      FS_IDX:  if (!cmd_full) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Q16.8 times Q8.16 gives Q24.24; the integer part is the cell coordinate.
  assign mx = (2*COORD_W)'(x_r) * (2*COORD_W)'(cfg.scale);
  assign my = (2*COORD_W)'(y_r) * (2*COORD_W)'(cfg.scale);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      id_r <= in_particle_id[ID_BITS-1:0];
      x_r  <= in_x_coord;
      y_r  <= in_y_coord;
      qr_r <= in_query_row;
      qc_r <= in_query_col;
    end
    if (state_r == FS_MUL) begin
      pcol_r <= mx[2*COORD_W-1:COORD_W];
      prow_r <= my[2*COORD_W-1:COORD_W];
    end
  end

  assign row  = (op_r == OP_GET) ? COORD_W'(qr_r) : prow_r;
  assign col  = (op_r == OP_GET) ? COORD_W'(qc_r) : pcol_r;
  assign inb  = (row < COORD_W'(cfg.rows)) && (col < COORD_W'(cfg.cols));
  assign idxf = IDXF_W'(row[DIM_W-1:0]) * IDXF_W'(cfg.cols) + IDXF_W'(col[DIM_W-1:0]);

  assign cmd_push = (state_r == FS_IDX) && !cmd_full;
  assign cmd.op   = op_r;
  assign cmd.id   = id_r;
  assign cmd.idx  = idxf[IDX_W-1:0];
  assign cmd.ok   = inb && ((IDXF_W+1)'(idxf) < (IDXF_W+1)'(MAX_CELLS));
endmodule
`default_nettype wire

[rtl/core/ugpb_cq.sv]
// Two-entry command queue between the front end and the bucket engine.
`timescale 1ns / 1ps
`default_nettype none
module ugpb_cq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ugpb_pkg::cmd_t wdata,
  output logic                full,
  input  wire logic           pop,
  output ugpb_pkg::cmd_t      rdata,
  output logic                empty
);
  import ugpb_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

[rtl/core/ugpb_back.sv]
// Bucket engine: count and entry memories, clear sweep and result streaming.
`timescale 1ns / 1ps
`default_nettype none
module ugpb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ugpb_pkg::cmd_t cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  output logic                init_busy,
  output ugpb_pkg::res_t      res,
  output logic                res_valid,
  input  wire logic           res_pop
);
  import ugpb_pkg::*;

  localparam logic [2:0] BS_IDLE  = 3'd0;
  localparam logic [2:0] BS_CLR   = 3'd1;
  localparam logic [2:0] BS_RDCNT = 3'd2;
  localparam logic [2:0] BS_RDENT = 3'd3;
  localparam logic [2:0] BS_WTENT = 3'd4;
  localparam logic [2:0] BS_EMIT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic             init_r, init_nxt;
  logic [IDX_W-1:0] sweep_r, sweep_nxt;
  logic [CNT_W-1:0] k_r, k_nxt, n_r, n_nxt;
  cmd_t             cmd_r;
  res_t             pend_r, pend_nxt;
  res_t             res_r, res_nxt;
  logic             valid_r, valid_nxt;
  logic             out_free;

  logic             cnt_we, cnt_re, ent_we, ent_re;
  logic [IDX_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic [ENT_AW-1:0] ent_waddr, ent_raddr;
  logic [ID_BITS-1:0] ent_rdata;
  logic [CNT_W-1:0] nc;

  ugpb_ram #(.W(CNT_W), .D(MAX_CELLS), .AW(IDX_W)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(cnt_re), .raddr(cmd.idx), .rdata(cnt_rdata)
  );

  ugpb_ram #(.W(ID_BITS), .D(ENT_D), .AW(ENT_AW)) u_ent (
    .clk, .we(ent_we), .waddr(ent_waddr), .wdata(cmd_r.id),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  assign out_free  = !valid_r || res_pop;
  assign init_busy = init_r;
  assign res       = res_r;
  assign res_valid = valid_r;
  assign nc        = (cnt_rdata > CNT_W'(CELL_CAPACITY)) ? CNT_W'(CELL_CAPACITY) : cnt_rdata;
  assign ent_waddr = ent_addr(cmd_r.idx, cnt_rdata);
  assign ent_raddr = ent_addr(cmd_r.idx, k_r);

  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    sweep_nxt = sweep_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    pend_nxt  = pend_r;
    res_nxt   = res_r;
    valid_nxt = valid_r && !res_pop;
    cmd_pop   = 1'b0;
    cnt_we    = 1'b0;
    cnt_re    = 1'b0;
    cnt_waddr = sweep_r;
    cnt_wdata = '0;
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    unique case (state_r)
      BS_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_CLEAR) begin
            sweep_nxt = '0;
            state_nxt = BS_CLR;
          end else if (!cmd.ok) begin
            pend_nxt  = '{status: ST_OUTSIDE, count: 5'd0, id: 16'd0, last: 1'b1};
            state_nxt = BS_EMIT;
          end else begin
            cnt_re    = 1'b1;
            state_nxt = BS_RDCNT;
          end
        end
      end
      BS_CLR: begin
        cnt_we = 1'b1;
        if (sweep_r == IDX_W'(MAX_CELLS - 1)) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = BS_IDLE;
          end else begin
            pend_nxt  = '{status: ST_OK, count: 5'd0, id: 16'd0, last: 1'b1};
            state_nxt = BS_EMIT;
          end
        end else begin
          sweep_nxt = sweep_r + IDX_W'(1);
        end
      end
      BS_RDCNT: begin
        if (cmd_r.op == OP_INSERT) begin
          if (cnt_rdata >= CNT_W'(CELL_CAPACITY)) begin
            pend_nxt = '{status: ST_FULL, count: 5'(cnt_rdata), id: 16'd0, last: 1'b1};
          end else begin
            ent_we    = 1'b1;
            cnt_we    = 1'b1;
            cnt_waddr = cmd_r.idx;
            cnt_wdata = cnt_rdata + CNT_W'(1);
            pend_nxt  = '{status: ST_OK, count: 5'(cnt_rdata + CNT_W'(1)),
                          id: 16'd0, last: 1'b1};
          end
          state_nxt = BS_EMIT;
        end else if (nc == '0) begin
          pend_nxt  = '{status: ST_OK, count: 5'd0, id: 16'd0, last: 1'b1};
          state_nxt = BS_EMIT;
        end else begin
          n_nxt     = nc;
          k_nxt     = '0;
          state_nxt = BS_RDENT;
        end
      end
      BS_RDENT: begin
        ent_re    = 1'b1;
        state_nxt = BS_WTENT;
      end
      BS_WTENT: begin
        // The entry read data holds until the next read, so a stall is safe here.
        if (out_free) begin
          res_nxt   = '{status: ST_OK, count: 5'(n_r), id: 16'(ent_rdata),
                        last: (k_r + CNT_W'(1) == n_r)};
          valid_nxt = 1'b1;
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = (k_r + CNT_W'(1) == n_r) ? BS_IDLE : BS_RDENT;
        end
      end
      BS_EMIT: begin
        if (out_free) begin
          res_nxt   = pend_r;
          valid_nxt = 1'b1;
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_CLR;
      init_r  <= 1'b1;
      sweep_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      sweep_r <= sweep_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    n_r    <= n_nxt;
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
  end
endmodule
`default_nettype wire

[rtl/core/uniform_grid_particle_binning.sv]
// Top level of the uniform grid particle binning block.
`timescale 1ns / 1ps
`default_nettype none
// Sorts particle ids into a grid of cells of up to CELL_CAPACITY ids each. The
// front end takes one item at a time (capture, coordinate multiply, index and
// bounds check), stalls while the command queue is full, and hands it through
// a two-entry command queue to the bucket engine. There an insert reads the
// count, updates it and emits the result; an outside-grid answer emits the result
// after the command pop; a get of n ids does one read of the entry memory per id;
// and a clear zeroes one count memory entry per cycle between the command pop and
// the result. After reset the same sweep runs with full held high; configuration
// writes are taken throughout and cfg_ready is always high.
module uniform_grid_particle_binning (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_particle_id,
  input  wire logic [23:0] in_x_coord,
  input  wire logic [23:0] in_y_coord,
  input  wire logic [9:0]  in_query_row,
  input  wire logic [9:0]  in_query_col,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_status,
  output logic [4:0]       out_cell_count,
  output logic [15:0]      out_stored_id,
  output logic             out_last
);
  import ugpb_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd_in, cmd_out;
  res_t res;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty, init_busy, res_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows  <= DIM_W'(32);
      cfg_r.cols  <= DIM_W'(32);
      cfg_r.scale <= SCALE_W'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS:  cfg_r.rows  <= cfg_data[DIM_W-1:0];
        REG_COLS:  cfg_r.cols  <= cfg_data[DIM_W-1:0];
        REG_SCALE: cfg_r.scale <= cfg_data[SCALE_W-1:0];
        default:   ;
      endcase
    end
  end

  ugpb_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .hold(init_busy),
    .in_push, .in_full, .in_operation, .in_particle_id,
    .in_x_coord, .in_y_coord, .in_query_row, .in_query_col,
    .cmd_push, .cmd(cmd_in), .cmd_full
  );

  ugpb_cq u_cq (
    .clk, .rst_n, .push(cmd_push), .wdata(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .rdata(cmd_out), .empty(cmd_empty)
  );

  ugpb_back u_back (
    .clk, .rst_n, .cmd(cmd_out), .cmd_empty, .cmd_pop, .init_busy,
    .res, .res_valid, .res_pop(out_pop)
  );

  assign out_empty      = !res_valid;
  assign out_status     = res.status;
  assign out_cell_count = res.count;
  assign out_stored_id  = res.id;
  assign out_last       = res.last;
endmodule
`default_nettype wire

[rtl/core/ugpb_checker.sv]
// Port-level checker for the particle binning block, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "uniform_grid_particle_binning_defines.svh"
module ugpb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [1:0]  out_status,
  input wire logic [4:0]  out_cell_count,
  input wire logic [15:0] out_stored_id,
  input wire logic        out_last
);
  import ugpb_pkg::*;

  `UGPB_ASSERT_NOW(a_outside_beat, clk, rst_n, !out_empty && out_status == ST_OUTSIDE, out_cell_count == 5'd0 && out_stored_id == 16'd0 && out_last, "outside-grid beat malformed")
  `UGPB_ASSERT_NOW(a_full_count, clk, rst_n, !out_empty && out_status == ST_FULL, out_cell_count == 5'(CELL_CAPACITY) && out_last, "full beat without full count")
  `UGPB_ASSERT_NOW(a_count_range, clk, rst_n, !out_empty, out_cell_count <= 5'(CELL_CAPACITY) && out_status != 2'd3, "beat fields out of range")
  `UGPB_ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_stored_id) && $stable(out_last), "stalled beat changed")
endmodule

bind uniform_grid_particle_binning ugpb_checker u_chk (.*);
`default_nettype wire

[bench/tb_uniform_grid_particle_binning.sv]
// Self-checking testbench for the uniform grid particle binning block.
`timescale 1ns / 1ps
module tb_uniform_grid_particle_binning;
  import ugpb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] id;
    logic [23:0] x;
    logic [23:0] y;
    logic [9:0]  qrow;
    logic [9:0]  qcol;
  } particle_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_ROWS;
  logic [23:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_operation = OP_CLEAR;
  logic [15:0] in_particle_id = '0;
  logic [23:0] in_x_coord = '0;
  logic [23:0] in_y_coord = '0;
  logic [9:0] in_query_row = '0;
  logic [9:0] in_query_col = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [1:0] out_status;
  logic [4:0] out_cell_count;
  logic [15:0] out_stored_id;
  logic out_last;

  uniform_grid_particle_binning dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow grid state and registers.
  logic [10:0] grid_rows_q;
  logic [10:0] grid_cols_q;
  logic [23:0] inv_cell_q;
  logic [4:0]  cell_fill [MAX_CELLS];
  logic [15:0] cell_ids [MAX_CELLS][CELL_CAPACITY];

  particle_op_t pending_ops[$];
  res_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  int in_wait = 0;
  int out_wait = 0;
  // Handshakes seen at the last rising edge, for the driver at the falling edge.
  bit in_acc = 1'b0;
  bit out_acc = 1'b0;

  function automatic bit locate_cell(input logic [31:0] row, input logic [31:0] col,
                                     output int idx);
    longint i;
    idx = 0;
    if (row >= grid_rows_q || col >= grid_cols_q) return 0;
    i = longint'(row) * grid_cols_q + col;
    if (i >= MAX_CELLS) return 0;
    idx = int'(i);
    return 1;
  endfunction

  function automatic void push_result(input logic [1:0] st, input logic [4:0] cnt,
                                      input logic [15:0] id, input logic lst);
    res_t r;
    r.status = st;
    r.count = cnt;
    r.id = id;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void bin_particle(input particle_op_t p);
    logic [47:0] cprod;
    logic [47:0] rprod;
    int idx;
    int n;
    case (p.op)
      OP_CLEAR: begin
        foreach (cell_fill[i]) cell_fill[i] = '0;
        push_result(ST_OK, 5'd0, 16'd0, 1'b1);
      end
      OP_INSERT: begin
        cprod = 48'(p.x) * 48'(inv_cell_q);
        rprod = 48'(p.y) * 48'(inv_cell_q);
        if (!locate_cell(32'(rprod >> 24), 32'(cprod >> 24), idx)) begin
          push_result(ST_OUTSIDE, 5'd0, 16'd0, 1'b1);
        end else if (cell_fill[idx] >= CELL_CAPACITY) begin
          push_result(ST_FULL, cell_fill[idx], 16'd0, 1'b1);
        end else begin
          cell_ids[idx][cell_fill[idx][3:0]] = p.id;
          cell_fill[idx] = cell_fill[idx] + 5'd1;
          push_result(ST_OK, cell_fill[idx], 16'd0, 1'b1);
        end
      end
      OP_GET: begin
        if (!locate_cell(32'(p.qrow), 32'(p.qcol), idx)) begin
          push_result(ST_OUTSIDE, 5'd0, 16'd0, 1'b1);
        end else if (cell_fill[idx] == 0) begin
          push_result(ST_OK, 5'd0, 16'd0, 1'b1);
        end else begin
          n = int'(cell_fill[idx]);
          for (int k = 0; k < n; k++) push_result(ST_OK, 5'(n), cell_ids[idx][k], k == n - 1);
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: one beat per accepted item, random gap before each.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        in_push <= 1'b0;
        in_wait <= $urandom_range(0, 5);
      end else if (!in_push && pending_ops.size() > 0) begin
        if (in_wait > 0) begin
          in_wait <= in_wait - 1;
        end else begin
          in_push <= 1'b1;
          in_operation <= pending_ops[0].op;
          in_particle_id <= pending_ops[0].id;
          in_x_coord <= pending_ops[0].x;
          in_y_coord <= pending_ops[0].y;
          in_query_row <= pending_ops[0].qrow;
          in_query_col <= pending_ops[0].qcol;
        end
      end
      if (out_acc) begin
        out_pop <= 1'b0;
        out_wait <= $urandom_range(0, 5);
      end else if (!out_pop) begin
        if (out_wait > 0) out_wait <= out_wait - 1;
        else out_pop <= 1'b1;
      end
    end
  end

  // Prediction happens at acceptance; the monitor checks each result beat.
  always @(posedge clk) begin
    particle_op_t p;
    res_t e;
    in_acc <= rst_n && in_push && !in_full;
    out_acc <= rst_n && out_pop && !out_empty;
    if (rst_n) begin
      if (in_push && !in_full) begin
        p = pending_ops.pop_front();
        bin_particle(p);
      end
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: status=%0d count=%0d id=%0h last=%0d",
                   $time, out_status, out_cell_count, out_stored_id, out_last);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_cell_count !== e.count) begin
            $display("%0t: cell_count expected %0d actual %0d", $time, e.count,
                     out_cell_count);
            errors++;
          end
          if (out_stored_id !== e.id) begin
            $display("%0t: stored_id expected %0h actual %0h", $time, e.id, out_stored_id);
            errors++;
          end
          if (out_last !== e.last) begin
            $display("%0t: last expected %0d actual %0d", $time, e.last, out_last);
            errors++;
          end
        end
      end
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_uniform_grid_particle_binning: FAIL");
        $finish;
      end
    end
  end

  function automatic particle_op_t make_op(input logic [1:0] op, input logic [15:0] id,
                                           input logic [23:0] x, input logic [23:0] y,
                                           input logic [9:0] r, input logic [9:0] c);
    particle_op_t p;
    p.op = op; p.id = id; p.x = x; p.y = y; p.qrow = r; p.qcol = c;
    return p;
  endfunction

  task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_ROWS: grid_rows_q = value[10:0];
      REG_COLS: grid_cols_q = value[10:0];
      default: inv_cell_q = value;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every expected beat has arrived, then lets a clear pass drain.
  task automatic drain_block();
    while (pending_ops.size() > 0 || in_push || expected_results.size() > 0) @(posedge clk);
    repeat (MAX_CELLS + 50) @(posedge clk);
  endtask

  // Coordinate in Q16.8 that lands inside cell index c at the current scale of 1.0.
  function automatic logic [23:0] coord_for(input int c);
    return 24'((c << 8) | $urandom_range(0, 255));
  endfunction

  task automatic random_phase(input int count, input int span_r, input int span_c);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 3)
        pending_ops.push_back(make_op(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                      $urandom));
      else if (sel < 6)
        pending_ops.push_back(make_op(OP_NONE, $urandom, $urandom, $urandom, $urandom,
                                      $urandom));
      else if (sel < 10)
        pending_ops.push_back(make_op(OP_INSERT, $urandom, $urandom, $urandom, $urandom,
                                      $urandom));
      else if (sel < 60)
        pending_ops.push_back(make_op(OP_INSERT, $urandom,
                                      coord_for($urandom_range(0, span_c)),
                                      coord_for($urandom_range(0, span_r)),
                                      $urandom, $urandom));
      else
        pending_ops.push_back(make_op(OP_GET, $urandom, $urandom, $urandom,
                                      $urandom_range(0, span_r), $urandom_range(0, span_c)));
    end
  endtask

  initial begin
    grid_rows_q = 11'd32;
    grid_cols_q = 11'd32;
    inv_cell_q = 24'd65536;
    foreach (cell_fill[i]) cell_fill[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of fields, overfill one cell, every operation.
    pending_ops.push_back(make_op(OP_GET, 0, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      pending_ops.push_back(make_op(OP_INSERT, (i == 0) ? 16'hFFFF : 16'(i), 24'h0000FF,
                                    24'h0000FF, 0, 0));
    pending_ops.push_back(make_op(OP_GET, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
    pending_ops.push_back(make_op(OP_INSERT, 16'h8000, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
    pending_ops.push_back(make_op(OP_INSERT, 16'h1234, 24'h001F00, 24'h001FFF, 0, 0));
    pending_ops.push_back(make_op(OP_GET, 0, 0, 0, 10'd31, 10'd31));
    pending_ops.push_back(make_op(OP_GET, 0, 0, 0, 10'h3FF, 10'h3FF));
    pending_ops.push_back(make_op(OP_NONE, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 10'h3FF, 10'h3FF));
    pending_ops.push_back(make_op(OP_CLEAR, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_GET, 0, 0, 0, 0, 0));
    random_phase(80, 33, 33);
    drain_block();

    // Wide grid and index overflow beyond the cell count, at a scale of 1.0.
    write_reg(REG_ROWS, 24'd1024);
    write_reg(REG_COLS, 24'd1024);
    write_reg(REG_SCALE, 24'd65536);
    random_phase(50, 3, 1023);
    drain_block();

    // Single cell with a large scale factor.
    write_reg(REG_ROWS, 24'd1);
    write_reg(REG_COLS, 24'd1);
    write_reg(REG_SCALE, 24'hFFFFFF);
    pending_ops.push_back(make_op(OP_INSERT, 16'h5555, 24'h000000, 24'h000000, 0, 0));
    pending_ops.push_back(make_op(OP_INSERT, 16'hAAAA, 24'h000001, 24'h000001, 0, 0));
    random_phase(40, 1, 1);
    drain_block();

    // Zero rows and a zero scale: every access lands outside.
    write_reg(REG_ROWS, 24'd0);
    write_reg(REG_COLS, 24'h7FF);
    write_reg(REG_SCALE, 24'd0);
    random_phase(30, 2, 2);
    drain_block();

    // An oversized row register value and a half-size scale.
    write_reg(REG_ROWS, 24'hFFFFFF);
    write_reg(REG_COLS, 24'd8);
    write_reg(REG_SCALE, 24'd32768);
    random_phase(100, 130, 9);
    drain_block();

    if (errors == 0)
      $display("tb_uniform_grid_particle_binning: PASS");
    else
      $display("tb_uniform_grid_particle_binning: FAIL");
    $finish;
  end
endmodule
